@@ design/jit_tier_promotion_table_assert.svh @@
// Assertion macros for the tier promotion table.
// JTPT_ASSERT is checked out of reset; JTPT_ASSERT_RST is checked on every edge.
`ifndef JIT_TIER_PROMOTION_TABLE_ASSERT_SVH
`define JIT_TIER_PROMOTION_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define JTPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define JTPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define JTPT_ASSERT(lbl, prop, msg)
`define JTPT_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ design/jtpt_pkg.sv @@
`default_nettype none

package jtpt_pkg;

  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned SlotIdxW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned HitCntW    = $clog2(SLOT_COUNT + 1);

  localparam int unsigned KindW      = 2;
  localparam int unsigned KeyW       = 64;
  localparam int unsigned TierW      = 3;
  localparam int unsigned CauseW     = 64;
  localparam int unsigned CntW       = 32;
  localparam int unsigned SlotUsedW  = 2;
  localparam int unsigned DeoptHitsW = 3;
  localparam int unsigned CfgAddrW   = 2;
  localparam int unsigned CfgDataW   = 32;

  localparam logic [CntW-1:0]  CntMax      = '1;
  localparam logic [CntW-1:0]  MiddleThrRst = CntW'(1000);
  localparam logic [CntW-1:0]  TopThrRst    = CntW'(10000);

  localparam logic [TierW-1:0] TierBase   = TierW'(1);
  localparam logic [TierW-1:0] TierMiddle = TierW'(2);
  localparam logic [TierW-1:0] TierTop    = TierW'(3);

  typedef enum logic [KindW-1:0] {
    KindCall    = 2'd0,
    KindCompile = 2'd1,
    KindDeopt   = 2'd2
  } kind_e;

  typedef enum logic [CfgAddrW-1:0] {
    CfgMiddleThr = 2'd0,
    CfgTopThr    = 2'd1,
    CfgTopEnable = 2'd2
  } cfg_reg_e;

  // Request from the control path to the code slot table.
  typedef struct packed {
    logic             compile;
    logic             deopt;
    logic [KeyW-1:0]  key;
    logic [TierW-1:0] tier;
  } slot_req_t;

  // What the slot table reports back for the same beat.
  typedef struct packed {
    logic                installed;
    logic                present;
    logic [SlotIdxW-1:0] slot;
    logic [HitCntW-1:0]  hits;
  } slot_rsp_t;

endpackage

`default_nettype wire

@@ design/jtpt_if.sv @@
`default_nettype none

interface jtpt_item_if import jtpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [KeyW-1:0]   func_key;
  logic [TierW-1:0]  tier_sel;
  logic [CauseW-1:0] deopt_cause;

  modport source (output valid, kind, func_key, tier_sel, deopt_cause, input ready);
  modport sink (input valid, kind, func_key, tier_sel, deopt_cause, output ready);
endinterface

interface jtpt_result_if import jtpt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TierW-1:0]      tier_now;
  logic [CntW-1:0]       calls_seen;
  logic                  middle_hot;
  logic                  top_hot;
  logic                  installed;
  logic                  already_present;
  logic [SlotUsedW-1:0]  slot_used;
  logic [DeoptHitsW-1:0] deopt_hits;

  modport source (output valid, tier_now, calls_seen, middle_hot, top_hot, installed,
                  already_present, slot_used, deopt_hits, input ready);
  modport sink (input valid, tier_now, calls_seen, middle_hot, top_hot, installed,
                already_present, slot_used, deopt_hits, output ready);
endinterface

interface jtpt_cfg_if import jtpt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

@@ design/jit_tier_promotion_table.sv @@
// Tier promotion table: each input beat (call, compile or deoptimise) passes through an
// input register, one stage of short logic that updates the saturating call counter, the
// current tier, the hotness flags and a four-slot code table, and an output register that
// holds exactly one result beat per input beat. A result is registered in the output
// register once its beat leaves the input register, which stalls while the output
// register is full and not taken. A new beat is accepted every cycle while the result
// side keeps up; the limit is the single update of the counter and the slot table per
// cycle. The configuration channel is always ready and should be written only while no
// beat is in flight. Writes to an index beyond the three registers are ignored.
`default_nettype none

`include "jit_tier_promotion_table_assert.svh"

module jit_tier_promotion_table import jtpt_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  jtpt_item_if.sink   item_i,
  jtpt_result_if.source result_o,
  jtpt_cfg_if.sink    cfg_i
);

  // Configuration registers.
  logic [CntW-1:0] mid_thr_q;
  logic [CntW-1:0] top_thr_q;
  logic            top_en_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_thr_q <= MiddleThrRst;
      top_thr_q <= TopThrRst;
      top_en_q  <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.addr))
        CfgMiddleThr: mid_thr_q <= cfg_i.wdata;
        CfgTopThr:    top_thr_q <= cfg_i.wdata;
        CfgTopEnable: top_en_q  <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  // Input register.
  logic              in_valid_q;
  logic [KindW-1:0]  kind_q;
  logic [KeyW-1:0]   key_q;
  logic [TierW-1:0]  tier_sel_q;
  logic [CauseW-1:0] cause_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_fire;

  assign advance      = in_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !in_valid_q || advance;
  assign in_fire      = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q     <= item_i.kind;
      key_q      <= item_i.func_key;
      tier_sel_q <= item_i.tier_sel;
      cause_q    <= item_i.deopt_cause;
    end
  end

  // Promotion state and its update.
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_inc;
  logic [TierW-1:0]  tier_q, tier_d;
  logic              mid_flag_q, mid_flag_d;
  logic              top_flag_q, top_flag_d;
  logic [CauseW-1:0] last_cause_q;
  logic              do_compile;
  logic              do_deopt;
  logic [TierW-1:0]  compile_tier;
  slot_req_t         slot_req;
  slot_rsp_t         slot_rsp;

  assign cnt_inc = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    cnt_d        = cnt_q;
    tier_d       = tier_q;
    mid_flag_d   = mid_flag_q;
    top_flag_d   = top_flag_q;
    do_compile   = 1'b0;
    do_deopt     = 1'b0;
    compile_tier = tier_sel_q;
    unique case (kind_e'(kind_q))
      KindCall: begin
        cnt_d = cnt_inc;
        if ((cnt_inc >= top_thr_q) && top_en_q) begin
          top_flag_d = 1'b1;
          if (tier_q < TierTop) begin
            do_compile   = 1'b1;
            compile_tier = TierTop;
          end
        end else if (cnt_inc >= mid_thr_q) begin
          mid_flag_d = 1'b1;
          if (tier_q < TierMiddle) begin
            do_compile   = 1'b1;
            compile_tier = TierMiddle;
          end
        end
      end
      KindCompile: begin
        do_compile = 1'b1;
      end
      KindDeopt: begin
        do_deopt   = 1'b1;
        tier_d     = TierBase;
        mid_flag_d = 1'b0;
        top_flag_d = 1'b0;
        cnt_d      = '0;
      end
      default: ;
    endcase
    if (do_compile) begin
      tier_d = compile_tier;
    end
  end

  // For a deoptimise the table is searched with the tier named by the beat.
  assign slot_req.compile = advance && do_compile;
  assign slot_req.deopt   = advance && do_deopt;
  assign slot_req.key     = key_q;
  assign slot_req.tier    = compile_tier;

  jtpt_slot_table u_slot_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (slot_req),
    .rsp_o  (slot_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      tier_q       <= TierBase;
      mid_flag_q   <= 1'b0;
      top_flag_q   <= 1'b0;
      last_cause_q <= '0;
    end else if (advance) begin
      cnt_q      <= cnt_d;
      tier_q     <= tier_d;
      mid_flag_q <= mid_flag_d;
      top_flag_q <= top_flag_d;
      if (do_deopt) begin
        last_cause_q <= cause_q;
      end
    end
  end

  // Output register.
  logic [TierW-1:0]      res_tier_q;
  logic [CntW-1:0]       res_cnt_q;
  logic                  res_mid_q;
  logic                  res_top_q;
  logic                  res_installed_q;
  logic                  res_present_q;
  logic [SlotUsedW-1:0]  res_slot_q;
  logic [DeoptHitsW-1:0] res_hits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= advance || (out_valid_q && !result_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_tier_q      <= tier_d;
      res_cnt_q       <= cnt_d;
      res_mid_q       <= mid_flag_d;
      res_top_q       <= top_flag_d;
      res_installed_q <= slot_rsp.installed;
      res_present_q   <= slot_rsp.present;
      res_slot_q      <= SlotUsedW'(slot_rsp.slot);
      res_hits_q      <= DeoptHitsW'(slot_rsp.hits);
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.tier_now        = res_tier_q;
  assign result_o.calls_seen      = res_cnt_q;
  assign result_o.middle_hot      = res_mid_q;
  assign result_o.top_hot         = res_top_q;
  assign result_o.installed       = res_installed_q;
  assign result_o.already_present = res_present_q;
  assign result_o.slot_used       = res_slot_q;
  assign result_o.deopt_hits      = res_hits_q;

  `JTPT_ASSERT(a_advance_fills_out, advance |=> out_valid_q, "processed beat did not reach the output register")
  `JTPT_ASSERT(a_in_held, (in_valid_q && !advance) |=> (in_valid_q && $stable(key_q)), "stalled input register changed")
  `JTPT_ASSERT(a_deopt_clears, (advance && kind_q == KindDeopt) |=> (res_cnt_q == '0 && res_tier_q == TierBase), "deoptimise did not reset counter and tier")
  `JTPT_ASSERT(a_install_xor_present, out_valid_q |-> !(res_installed_q && res_present_q), "slot both installed and already present")
  `JTPT_ASSERT(a_call_counter_rises, (advance && kind_q == KindCall) |=> (cnt_q >= $past(cnt_q)), "call counter decreased on a call")
  `JTPT_ASSERT_RST(a_reset_idle, !rst_ni |-> (!out_valid_q && !in_valid_q), "pipeline holds a beat during reset")

endmodule

`default_nettype wire

@@ design/jtpt_slot_table.sv @@
`default_nettype none

module jtpt_slot_table import jtpt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  slot_req_t req_i,
  output slot_rsp_t rsp_o
);

  logic [KeyW-1:0]  hash_q     [SLOT_COUNT];
  logic [TierW-1:0] tier_q     [SLOT_COUNT];
  logic             on_stack_q [SLOT_COUNT];
  logic             opt_q      [SLOT_COUNT];
  logic [CntW-1:0]  deopts_q   [SLOT_COUNT];

  logic [SLOT_COUNT-1:0] match_vec;
  logic [SLOT_COUNT-1:0] free_vec;
  logic [SLOT_COUNT-1:0] hit_vec;

  logic                match_any;
  logic [SlotIdxW-1:0] match_idx;
  logic                free_any;
  logic [SlotIdxW-1:0] free_idx;
  logic [HitCntW-1:0]  hit_cnt;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match_vec[i] = (hash_q[i] == req_i.key) && (tier_q[i] == req_i.tier);
      free_vec[i]  = (hash_q[i] == '0);
      hit_vec[i]   = (tier_q[i] == req_i.tier) && on_stack_q[i];
    end
  end

  // Lowest-numbered slot wins in both searches.
  always_comb begin
    match_any = 1'b0;
    match_idx = '0;
    free_any  = 1'b0;
    free_idx  = '0;
    hit_cnt   = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!match_any && match_vec[i]) begin
        match_any = 1'b1;
        match_idx = SlotIdxW'(i);
      end
      if (!free_any && free_vec[i]) begin
        free_any = 1'b1;
        free_idx = SlotIdxW'(i);
      end
      hit_cnt = hit_cnt + HitCntW'(hit_vec[i]);
    end
  end

  always_comb begin
    rsp_o.present   = req_i.compile && match_any;
    rsp_o.installed = req_i.compile && !match_any && free_any;
    rsp_o.hits      = req_i.deopt ? hit_cnt : '0;
    if (rsp_o.present) begin
      rsp_o.slot = match_idx;
    end else if (rsp_o.installed) begin
      rsp_o.slot = free_idx;
    end else begin
      rsp_o.slot = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        hash_q[i]     <= '0;
        tier_q[i]     <= '0;
        on_stack_q[i] <= 1'b0;
        opt_q[i]      <= 1'b0;
        deopts_q[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (rsp_o.installed && (free_idx == SlotIdxW'(i))) begin
          hash_q[i]     <= req_i.key;
          tier_q[i]     <= req_i.tier;
          on_stack_q[i] <= 1'b1;
          opt_q[i]      <= (req_i.tier >= TierTop);
          deopts_q[i]   <= '0;
        end else if (req_i.deopt && hit_vec[i]) begin
          on_stack_q[i] <= 1'b0;
          opt_q[i]      <= 1'b0;
          if (deopts_q[i] != CntMax) begin
            deopts_q[i] <= deopts_q[i] + 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/sv/jtpt_outcome_checker.sv @@
`timescale 1ns / 1ps

module jtpt_outcome_checker import jtpt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  jtpt_item_if   item_i,
  jtpt_result_if result_i,
  jtpt_cfg_if    cfg_i,
  output int     outcomes_waiting_o,
  output int     mismatches_o
);

  localparam int unsigned PrintCap = 200;

  typedef struct packed {
    logic [TierW-1:0]      tier_now;
    logic [CntW-1:0]       calls_seen;
    logic                  middle_hot;
    logic                  top_hot;
    logic                  installed;
    logic                  already_present;
    logic [SlotUsedW-1:0]  slot_used;
    logic [DeoptHitsW-1:0] deopt_hits;
  } tier_outcome_t;

  tier_outcome_t outcome_q[$];
  tier_outcome_t due_beat;
  tier_outcome_t new_beat;
  int            mismatch_count;

  // Shadow of the configuration registers and of the block's state.
  logic [CntW-1:0]   mid_thr;
  logic [CntW-1:0]   top_thr;
  logic              top_en;
  logic [CntW-1:0]   calls_shadow;
  logic [TierW-1:0]  tier_cur;
  logic              mid_hot_q;
  logic              top_hot_q;
  logic [CauseW-1:0] cause_q;
  logic [KeyW-1:0]   slot_key       [SLOT_COUNT];
  logic [TierW-1:0]  slot_tier_q    [SLOT_COUNT];
  logic              slot_live      [SLOT_COUNT];
  logic              slot_opt       [SLOT_COUNT];
  logic [CntW-1:0]   slot_deopt_cnt [SLOT_COUNT];

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is 0x%0h, should be 0x%0h", name, got, want));
    end
  endtask

  // A matching hash and tier wins over a free slot; a zero hash counts as free.
  task automatic install_code(input logic [KeyW-1:0] key, input logic [TierW-1:0] tier,
                              inout tier_outcome_t o);
    logic done;
    done     = 1'b0;
    tier_cur = tier;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!done && slot_key[i] == key && slot_tier_q[i] == tier) begin
        o.already_present = 1'b1;
        o.slot_used       = SlotUsedW'(i);
        done              = 1'b1;
      end
    end
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!done && slot_key[i] == '0) begin
        slot_key[i]       = key;
        slot_tier_q[i]    = tier;
        slot_deopt_cnt[i] = '0;
        slot_opt[i]       = (tier >= TierTop);
        slot_live[i]      = 1'b1;
        o.installed       = 1'b1;
        o.slot_used       = SlotUsedW'(i);
        done              = 1'b1;
      end
    end
  endtask

  task automatic advance_tier_table(input logic [KindW-1:0] kind,
                                    input logic [KeyW-1:0] key,
                                    input logic [TierW-1:0] tier,
                                    input logic [CauseW-1:0] cause,
                                    output tier_outcome_t o);
    int hits;
    hits = 0;
    o    = '0;
    case (kind)
      KindCall: begin
        if (calls_shadow != CntMax) calls_shadow++;
        if (calls_shadow >= top_thr && top_en) begin
          top_hot_q = 1'b1;
          if (tier_cur < TierTop) install_code(key, TierTop, o);
        end else if (calls_shadow >= mid_thr) begin
          mid_hot_q = 1'b1;
          if (tier_cur < TierMiddle) install_code(key, TierMiddle, o);
        end
      end
      KindCompile: begin
        install_code(key, tier, o);
      end
      KindDeopt: begin
        cause_q  = cause;
        tier_cur = TierBase;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_tier_q[i] == tier && slot_live[i]) begin
            if (slot_deopt_cnt[i] != CntMax) slot_deopt_cnt[i]++;
            slot_live[i] = 1'b0;
            slot_opt[i]  = 1'b0;
            hits++;
          end
        end
        top_hot_q    = 1'b0;
        mid_hot_q    = 1'b0;
        calls_shadow = '0;
      end
      default: begin
      end
    endcase
    o.tier_now   = tier_cur;
    o.calls_seen = calls_shadow;
    o.middle_hot = mid_hot_q;
    o.top_hot    = top_hot_q;
    o.deopt_hits = DeoptHitsW'(hits);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_thr      = MiddleThrRst;
      top_thr      = TopThrRst;
      top_en       = 1'b1;
      calls_shadow = '0;
      tier_cur     = TierBase;
      mid_hot_q    = 1'b0;
      top_hot_q    = 1'b0;
      cause_q      = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_key[i]       = '0;
        slot_tier_q[i]    = '0;
        slot_live[i]      = 1'b0;
        slot_opt[i]       = 1'b0;
        slot_deopt_cnt[i] = '0;
      end
      outcome_q.delete();
      mismatch_count      = 0;
      outcomes_waiting_o <= 0;
      mismatches_o       <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.addr)
          CfgMiddleThr: mid_thr = cfg_i.wdata;
          CfgTopThr:    top_thr = cfg_i.wdata;
          CfgTopEnable: top_en  = cfg_i.wdata[0];
          default: begin
          end
        endcase
      end
      // The result of a beat accepted at this edge cannot be out yet, so the
      // result side is checked before the new beat is added.
      if (result_i.valid && result_i.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result beat arrived with no item outstanding");
        end else begin
          due_beat = outcome_q.pop_front();
          compare_field("tier_now", 64'(result_i.tier_now), 64'(due_beat.tier_now));
          compare_field("calls_seen", 64'(result_i.calls_seen), 64'(due_beat.calls_seen));
          compare_field("middle_hot", 64'(result_i.middle_hot), 64'(due_beat.middle_hot));
          compare_field("top_hot", 64'(result_i.top_hot), 64'(due_beat.top_hot));
          compare_field("installed", 64'(result_i.installed), 64'(due_beat.installed));
          compare_field("already_present", 64'(result_i.already_present),
                        64'(due_beat.already_present));
          compare_field("slot_used", 64'(result_i.slot_used), 64'(due_beat.slot_used));
          compare_field("deopt_hits", 64'(result_i.deopt_hits), 64'(due_beat.deopt_hits));
        end
      end
      if (item_i.valid && item_i.ready) begin
        advance_tier_table(item_i.kind, item_i.func_key, item_i.tier_sel,
                           item_i.deopt_cause, new_beat);
        outcome_q.push_back(new_beat);
      end
      outcomes_waiting_o <= outcome_q.size();
      mismatches_o       <= mismatch_count;
    end
  end

endmodule

@@ tb/sv/tb_jit_tier_promotion_table.sv @@
`timescale 1ns / 1ps

module tb_jit_tier_promotion_table;
  import jtpt_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam logic [KeyW-1:0]  KeyOnes    = '1;
  localparam logic [CntW-1:0]  ThrMax     = '1;
  localparam int unsigned      RunLimit   = 400000;
  localparam int unsigned      PhaseCount = 12;
  localparam int unsigned      PhaseItems = 115;
  localparam int unsigned      TailItems  = 50;
  localparam int unsigned      HoldCycles = 80;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          hold_off_asked = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          outcomes_waiting;
  int          mismatches;
  int unsigned cycle_count = 0;
  logic [KeyW-1:0] spare_key;

  jtpt_item_if   item_if ();
  jtpt_result_if result_if ();
  jtpt_cfg_if    cfg_if ();

  jit_tier_promotion_table u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  jtpt_outcome_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .item_i             (item_if),
    .result_i           (result_if),
    .cfg_i              (cfg_if),
    .outcomes_waiting_o (outcomes_waiting),
    .mismatches_o       (mismatches)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RunLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is asked for.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_off_asked) begin
        hold_seen = hold_off_asked;
        hold_left = HoldCycles;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [KindW-1:0] kind, input logic [KeyW-1:0] key,
                           input logic [TierW-1:0] tier, input logic [CauseW-1:0] cause);
    while ($urandom_range(99) < src_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.kind        <= kind;
    item_if.func_key    <= key;
    item_if.tier_sel    <= tier;
    item_if.deopt_cause <= cause;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
  endtask

  // Stops offering beats and waits until every outstanding result is out.
  task automatic drain_results();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outcomes_waiting != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.wdata <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_thresholds(input logic [CntW-1:0] mid, input logic [CntW-1:0] top,
                                input logic en);
    write_reg(CfgMiddleThr, mid);
    write_reg(CfgTopThr, top);
    write_reg(CfgTopEnable, CfgDataW'(en));
  endtask

  // Nonzero keys are kept to two pairings that are already in the table, so
  // that only zero hashes land in the free slots and those stay reusable.
  // Fresh keys fill the table for good and are only used at the very end.
  task automatic send_random_item(input bit fresh);
    int              roll;
    logic [KindW-1:0] kind;
    logic [KeyW-1:0]  key;
    logic [TierW-1:0] tier;
    roll = $urandom_range(99);
    if (roll < 60) kind = KindCall;
    else if (roll < 82) kind = KindCompile;
    else if (roll < 96) kind = KindDeopt;
    else kind = KindUnused;
    tier = TierW'($urandom_range(7));
    key  = '0;
    if (fresh && $urandom_range(1) == 1) begin
      key = {$urandom, $urandom};
    end else if (kind == KindCompile) begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        key  = KeyOnes;
        tier = TierTop;
      end else if (roll < 30) begin
        key  = spare_key;
        tier = TierMiddle;
      end
    end else if (kind == KindDeopt || kind == KindUnused) begin
      key = {$urandom, $urandom};
    end
    send_item(kind, key, tier, {$urandom, $urandom});
  endtask

  initial begin
    rst_ni              <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.kind        <= KindCall;
    item_if.func_key    <= '0;
    item_if.tier_sel    <= '0;
    item_if.deopt_cause <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.addr         <= CfgMiddleThr;
    cfg_if.wdata        <= '0;
    spare_key = {$urandom, $urandom} | 64'd1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first under the reset thresholds.
    send_item(KindCall, '0, 3'd0, '0);
    send_item(KindCompile, '0, 3'd0, '0);          // zero hash matches a free slot
    send_item(KindCompile, KeyOnes, TierTop, '0);
    send_item(KindCompile, KeyOnes, TierTop, '0);
    send_item(KindCompile, spare_key, TierMiddle, '0);
    send_item(KindCompile, '0, 3'd7, '0);
    send_item(KindCompile, '0, 3'd7, '0);
    send_item(KindCompile, '0, 3'd4, '0);
    send_item(KindDeopt, '0, 3'd4, KeyOnes);
    send_item(KindDeopt, '0, TierTop, '0);
    send_item(KindDeopt, '0, TierTop, '0);
    send_item(KindUnused, KeyOnes, 3'd7, KeyOnes);
    send_item(KindCompile, '0, 3'd5, '0);
    send_item(KindCompile, '0, TierBase, '0);
    send_item(KindDeopt, '0, TierBase, '0);
    drain_results();
    set_thresholds(32'd2, 32'd4, 1'b1);
    repeat (4) send_item(KindCall, '0, 3'd0, '0);
    drain_results();
    set_thresholds(32'd2, 32'd4, 1'b0);
    send_item(KindCall, '0, 3'd0, '0);
    send_item(KindDeopt, '0, TierMiddle, '0);
    repeat (2) send_item(KindCall, '0, 3'd0, '0);
    drain_results();
    set_thresholds('0, '0, 1'b1);
    send_item(KindCall, '0, 3'd0, '0);
    drain_results();
    set_thresholds(ThrMax, ThrMax, 1'b1);
    send_item(KindCall, KeyOnes, 3'd7, '0);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      if (p < 4) begin
        src_idle_pct  = 26;
        sink_idle_pct = 76;
      end else if (p < 8) begin
        src_idle_pct  = 76;
        sink_idle_pct = 26;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      case (p)
        2:       set_thresholds('0, '0, 1'b1);
        5:       set_thresholds(ThrMax, ThrMax, 1'b1);
        7:       set_thresholds(ThrMax, 32'd3, 1'b1);
        9:       set_thresholds(32'd4, 32'd9, 1'b0);
        default: set_thresholds($urandom_range(12), $urandom_range(24),
                                1'($urandom_range(1)));
      endcase
      // The sender keeps offering beats while the result side holds off, so
      // the pipeline fills and backs up onto the input.
      if (p == 1 || p == 9) hold_off_asked++;
      repeat (PhaseItems) send_random_item(1'b0);
    end

    // Fresh keys can fill the free slots, after which the rest runs against a full table.
    drain_results();
    set_thresholds($urandom_range(6), $urandom_range(12), 1'b1);
    repeat (TailItems) send_random_item(1'b1);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
